/* design/ssgd_pkg.sv */
// Package for the switch-scan and gaze-dwell selector.
// Holds payload structs, request codes, register indexes and sizes; no dependencies.
package ssgd_pkg;

    localparam int MaxTargets = 16;
    localparam int IdxBits    = $clog2(MaxTargets);
    localparam int CntBits    = $clog2(MaxTargets + 1);
    localparam int TimerBits  = 17;
    localparam logic [TimerBits-1:0] TimerMax = '1;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_GAZE  = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    localparam logic [2:0] REG_SCAN_EN   = 3'd0;
    localparam logic [2:0] REG_PERIOD    = 3'd1;
    localparam logic [2:0] REG_REVERSE   = 3'd2;
    localparam logic [2:0] REG_TWO_SW    = 3'd3;
    localparam logic [2:0] REG_GAZE_EN   = 3'd4;
    localparam logic [2:0] REG_ALPHA     = 3'd5;
    localparam logic [2:0] REG_DWELL     = 3'd6;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        size_w;
        logic [14:0]        size_h;
        logic [15:0]        elapsed;
        logic               select_pressed;
        logic               next_pressed;
    } t_in;

    typedef struct packed {
        logic [3:0] focus_index;
        logic       focus_valid;
        logic       scan_activate;
        logic [3:0] gaze_index;
        logic       gaze_valid;
        logic       gaze_activate;
        logic [4:0] target_count;
        logic       table_full;
    } t_out;

    // Target rectangle in pixels: left, top, right, bottom (17-bit signed edges).
    typedef struct packed {
        logic signed [16:0] x0;
        logic signed [16:0] y0;
        logic signed [16:0] x1;
        logic signed [16:0] y1;
    } t_rect;

    // Beat passed from cell to cell during a hit-test sweep.
    typedef struct packed {
        logic               hit;
        logic [IdxBits-1:0] idx;
    } t_hit;

endpackage

/* design/ssgd_cell.sv */
// One target cell: holds a rectangle and tests the gaze point against it.
// Depends on ssgd_pkg. Cells form a chain that carries the first-hit result.
module ssgd_cell
    import ssgd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  t_rect              i_rect,
    input  logic [IdxBits-1:0] i_my_idx,
    input  logic               i_live,
    input  logic signed [33:0] i_gx,
    input  logic signed [33:0] i_gy,
    input  t_hit               i_hit,
    output t_hit               o_hit
);

    t_rect r_rect;
    logic  inside_w;
    logic signed [17:0] gx_int_w, gy_int_w;
    logic signed [17:0] x0_w, y0_w, x1_w, y1_w;

    // Rectangle storage, written on add.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rect <= i_rect;
        end
    end

    // Integer part of the smoothed point and sign-extended edges.
    assign gx_int_w = i_gx[33:16];
    assign gy_int_w = i_gy[33:16];
    assign x0_w     = {r_rect.x0[16], r_rect.x0};
    assign y0_w     = {r_rect.y0[16], r_rect.y0};
    assign x1_w     = {r_rect.x1[16], r_rect.x1};
    assign y1_w     = {r_rect.y1[16], r_rect.y1};

    // Inclusive hit test on the integer part of the smoothed point.
    // floor(s) >= x0 equals s >= x0*65536; s <= x1*65536 needs exact fraction.
    assign inside_w = i_live
        && (gx_int_w >= x0_w)
        && ((gx_int_w < x1_w) || ((gx_int_w == x1_w) && (i_gx[15:0] == '0)))
        && (gy_int_w >= y0_w)
        && ((gy_int_w < y1_w) || ((gy_int_w == y1_w) && (i_gy[15:0] == '0)));

    // Earlier hit wins; otherwise this cell claims it.
    always_comb begin
        o_hit = i_hit;
        if (!i_hit.hit && inside_w) begin
            o_hit.hit = 1'b1;
            o_hit.idx = i_my_idx;
        end
    end

endmodule

/* design/ssgd_smooth.sv */
// Exponential smoother for one gaze axis.
// Depends on ssgd_pkg. Multiplies old and raw by their weights in turn.
module ssgd_smooth
    import ssgd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [16:0]        i_alpha,
    input  logic signed [15:0] i_raw,
    output logic signed [33:0] o_val
);

    logic signed [33:0] r_val;
    logic signed [51:0] r_prod;
    logic               r_phase;
    logic [16:0]        a_w;
    logic signed [51:0] old_prod_w;
    logic signed [51:0] raw_prod_w;
    logic signed [51:0] n_sum;

    assign a_w   = (i_alpha > 17'd65536) ? 17'd65536 : i_alpha;
    // Both products are formed at full width from sign-extended operands.
    assign old_prod_w = 52'(r_val) * 52'($signed({1'b0, 17'd65536 - a_w}));
    assign raw_prod_w = 52'(signed'({i_raw, 16'd0})) * 52'($signed({1'b0, a_w}));
    // old*(65536-a) + raw*65536*a, then arithmetic shift by 16 floors it.
    assign n_sum = r_prod + raw_prod_w;

    // Phase 0 forms the old term, phase 1 adds the raw term and stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val   <= '0;
            r_phase <= 1'b0;
        end else if (i_start) begin
            r_prod  <= old_prod_w;
            r_phase <= 1'b1;
        end else if (r_phase) begin
            r_val   <= 34'(n_sum >>> 16);
            r_phase <= 1'b0;
        end
    end

    assign o_val = r_val;

endmodule

/* design/switch_scan_and_gaze_dwell_selector_unit.sv */
// Switch-scan and gaze-dwell selector, top level.
// Depends on ssgd_pkg, ssgd_cell and ssgd_smooth.
//
// Usage: items enter on i_in (valid/stall), one result beat leaves on o_out
// for each item. Items carry add, clear, gaze sample or tick requests.
// Registers sit on an APB-style port at byte addresses 4*i; pready is tied high.
// Add, clear, gaze sample and ticks without gaze raise o_out_valid after
// S_SM0 and S_OUT. A tick with gaze enabled goes through S_SM0 to form the old
// smoother term, S_SM1 to add the raw term, S_HIT for the hit test through the
// chain of target cells, S_DWELL to update the dwell timer and S_OUT to load the
// result. One item is in flight at a time and the next is taken the cycle after
// the result beat leaves.
// The result sits in an output register; while the receiver stalls it holds,
// and no new item is taken until it leaves.
// Reset (synchronous, active low) empties the table, removes focus and dwell,
// sets forward scan and zero timers, and loads register defaults. The target
// storage itself is not cleared; only entries below the count are used.
module switch_scan_and_gaze_dwell_selector_unit
    import ssgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {S_IDLE, S_SM0, S_SM1, S_HIT, S_DWELL, S_OUT} t_state;

    t_state r_state;
    t_in    r_item;
    t_out   r_out;
    logic   r_out_valid;

    logic              r_scan_en, r_rev, r_two, r_gaze_en;
    logic [15:0]       r_period, r_dwell_time;
    logic [16:0]       r_alpha;

    logic [CntBits-1:0] r_count;
    logic [IdxBits-1:0] r_scan_pos;
    logic               r_scan_valid, r_fwd;
    logic [TimerBits-1:0] r_scan_timer, r_dwell_timer;
    logic signed [15:0] r_raw_x, r_raw_y;
    logic               r_dw_valid;
    logic [IdxBits-1:0] r_dw_idx;
    logic               r_sact, r_gact, r_full;
    t_hit               r_hit;

    logic               accept_w, cfg_wr_w, smooth_start_w;
    logic signed [33:0] gx_w, gy_w;
    t_hit               chain_w [MaxTargets+1];
    t_rect              rect_w;
    logic [TimerBits:0] scan_sum_w, dwell_sum_w;
    logic [TimerBits-1:0] scan_sat_w, dwell_sat_w;

    assign pready      = 1'b1;
    assign cfg_wr_w    = psel && penable && pwrite;
    assign accept_w    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Register read mux.
    always_comb begin
        unique case (paddr[4:2])
            REG_SCAN_EN: prdata = 32'(r_scan_en);
            REG_PERIOD:  prdata = 32'(r_period);
            REG_REVERSE: prdata = 32'(r_rev);
            REG_TWO_SW:  prdata = 32'(r_two);
            REG_GAZE_EN: prdata = 32'(r_gaze_en);
            REG_ALPHA:   prdata = 32'(r_alpha);
            REG_DWELL:   prdata = 32'(r_dwell_time);
            default:     prdata = '0;
        endcase
    end

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_en    <= 1'b0;
            r_period     <= 16'd1000;
            r_rev        <= 1'b0;
            r_two        <= 1'b0;
            r_gaze_en    <= 1'b0;
            r_alpha      <= 17'd16384;
            r_dwell_time <= 16'd1500;
        end else if (cfg_wr_w) begin
            unique case (paddr[4:2])
                REG_SCAN_EN: r_scan_en    <= pwdata[0];
                REG_PERIOD:  r_period     <= pwdata[15:0];
                REG_REVERSE: r_rev        <= pwdata[0];
                REG_TWO_SW:  r_two        <= pwdata[0];
                REG_GAZE_EN: r_gaze_en    <= pwdata[0];
                REG_ALPHA:   r_alpha      <= pwdata[16:0];
                REG_DWELL:   r_dwell_time <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Gaze smoothers, one per axis; they run only on ticks with gaze enabled.
    assign smooth_start_w = (r_state == S_SM0) && (r_item.req_type == REQ_TICK) && r_gaze_en;
    ssgd_smooth u_smx (.i_clk, .i_rst_n, .i_start(smooth_start_w), .i_alpha(r_alpha),
                       .i_raw(r_raw_x), .o_val(gx_w));
    ssgd_smooth u_smy (.i_clk, .i_rst_n, .i_start(smooth_start_w), .i_alpha(r_alpha),
                       .i_raw(r_raw_y), .o_val(gy_w));

    // Chain of target cells carrying the first hit.
    assign rect_w.x0 = {r_item.pos_x[15], r_item.pos_x};
    assign rect_w.y0 = {r_item.pos_y[15], r_item.pos_y};
    assign rect_w.x1 = {r_item.pos_x[15], r_item.pos_x} + {2'b00, r_item.size_w};
    assign rect_w.y1 = {r_item.pos_y[15], r_item.pos_y} + {2'b00, r_item.size_h};
    assign chain_w[0] = '0;

    for (genvar g = 0; g < MaxTargets; g++) begin : g_cell
        ssgd_cell u_cell (
            .i_clk,
            .i_load  (r_state == S_SM0 && r_item.req_type == REQ_ADD
                      && r_count == CntBits'(g)),
            .i_rect  (rect_w),
            .i_my_idx(IdxBits'(g)),
            .i_live  (r_count > CntBits'(g)),
            .i_gx    (gx_w),
            .i_gy    (gy_w),
            .i_hit   (chain_w[g]),
            .o_hit   (chain_w[g+1])
        );
    end

    assign scan_sum_w  = {1'b0, r_scan_timer} + (TimerBits+1)'(r_item.elapsed);
    assign scan_sat_w  = scan_sum_w[TimerBits] ? TimerMax : scan_sum_w[TimerBits-1:0];
    assign dwell_sum_w = {1'b0, r_dwell_timer} + (TimerBits+1)'(r_item.elapsed);
    assign dwell_sat_w = dwell_sum_w[TimerBits] ? TimerMax : dwell_sum_w[TimerBits-1:0];

    // Sequencer and block state.
    always_ff @(posedge i_clk) begin
        logic signed [CntBits+1:0] idx;
        logic signed [CntBits+1:0] n;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_count       <= '0;
            r_scan_pos    <= '0;
            r_scan_valid  <= 1'b0;
            r_fwd         <= 1'b1;
            r_scan_timer  <= '0;
            r_dwell_timer <= '0;
            r_raw_x       <= '0;
            r_raw_y       <= '0;
            r_dw_valid    <= 1'b0;
            r_dw_idx      <= '0;
            r_sact        <= 1'b0;
            r_gact        <= 1'b0;
            r_full        <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept_w) begin
                        r_item  <= i_in;
                        r_sact  <= 1'b0;
                        r_gact  <= 1'b0;
                        r_full  <= 1'b0;
                        r_state <= S_SM0;
                    end
                end
                S_SM0: begin
                    r_state <= S_OUT;
                    case (t_req'(r_item.req_type))
                        REQ_ADD: begin
                            if (r_count < CntBits'(MaxTargets)) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_full <= 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            r_count      <= '0;
                            r_scan_pos   <= '0;
                            r_scan_valid <= 1'b0;
                        end
                        REQ_GAZE: begin
                            r_raw_x <= r_item.pos_x;
                            r_raw_y <= r_item.pos_y;
                        end
                        default: begin
                            // Switch scan step, done here while smoothers start.
                            if (r_scan_en && r_count != '0) begin
                                n   = (CntBits+2)'(r_count);
                                idx = r_scan_valid ? (CntBits+2)'(r_scan_pos) : '1;
                                if (scan_sat_w >= TimerBits'(r_period)) begin
                                    r_scan_timer <= '0;
                                    if (r_fwd) begin
                                        idx = (CntBits+2)'(idx + 1);
                                        if (idx >= n) begin
                                            if (r_rev) begin
                                                r_fwd <= 1'b0;
                                                idx = (CntBits+2)'(n - 2);
                                            end else begin
                                                idx = '0;
                                            end
                                        end
                                    end else begin
                                        idx = (CntBits+2)'(idx - 1);
                                        if (idx < 0) begin
                                            r_fwd <= 1'b1;
                                            idx = (CntBits+2)'(1);
                                        end
                                    end
                                    if (idx > n - 1) idx = (CntBits+2)'(n - 1);
                                    if (idx < 0) idx = '0;
                                    r_scan_pos   <= IdxBits'(idx);
                                    r_scan_valid <= 1'b1;
                                    r_sact <= r_item.select_pressed;
                                end else begin
                                    r_scan_timer <= scan_sat_w;
                                    r_sact <= r_item.select_pressed && r_scan_valid;
                                end
                                if (r_two && r_item.next_pressed) begin
                                    r_scan_timer <= TimerBits'(r_period);
                                end
                            end
                            if (r_gaze_en) r_state <= S_SM1;
                        end
                    endcase
                end
                S_SM1: r_state <= S_HIT;
                S_HIT: begin
                    r_hit   <= chain_w[MaxTargets];
                    r_state <= S_DWELL;
                end
                S_DWELL: begin
                    // Dwell timer against the first-hit target.
                    if (!r_hit.hit) begin
                        r_dw_valid    <= 1'b0;
                        r_dw_idx      <= '0;
                        r_dwell_timer <= '0;
                    end else if (r_dw_valid && r_dw_idx == r_hit.idx) begin
                        if (dwell_sat_w >= TimerBits'(r_dwell_time)) begin
                            r_dwell_timer <= '0;
                            r_gact        <= 1'b1;
                        end else begin
                            r_dwell_timer <= dwell_sat_w;
                        end
                    end else begin
                        r_dw_valid    <= 1'b1;
                        r_dw_idx      <= r_hit.idx;
                        r_dwell_timer <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out.focus_index   <= r_scan_valid ? 4'(r_scan_pos) : 4'd0;
                        r_out.focus_valid   <= r_scan_valid;
                        r_out.scan_activate <= r_sact;
                        r_out.gaze_index    <= (r_dw_valid && CntBits'(r_dw_idx) < r_count)
                                               ? 4'(r_dw_idx) : 4'd0;
                        r_out.gaze_valid    <= r_dw_valid && CntBits'(r_dw_idx) < r_count;
                        r_out.gaze_activate <= r_gact;
                        r_out.target_count  <= 5'(r_count);
                        r_out.table_full    <= r_full;
                    end else if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // Count never exceeds the table size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntBits'(MaxTargets)) else $error("target count overflow");
    // No item is taken while a result is pending.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall) else $error("accept while result pending");
    // Focus only exists with a non-empty table.
    a_focus_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_valid |-> (r_count != '0)) else $error("focus on empty table");
`endif

endmodule
